// File: rtl/mse_pkg.sv
// ============================================================================
// mse_pkg: shared types and constants for the MIPS subset executor
// Command codes, field widths and the request records passed from the
// front end through the queue to the execute unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

  localparam int unsigned MemWords     = 1024;
  localparam int unsigned ProgramLines = 1024;
  localparam int unsigned MemAw        = $clog2(MemWords);
  localparam int unsigned QDepth       = 2;

  typedef enum logic [3:0] {
    CMD_NOP  = 4'd0,
    CMD_J    = 4'd1,
    CMD_ADD  = 4'd2,
    CMD_SUB  = 4'd3,
    CMD_MUL  = 4'd4,
    CMD_DIV  = 4'd5,
    CMD_ADDI = 4'd6,
    CMD_SUBI = 4'd7,
    CMD_LW   = 4'd8,
    CMD_SW   = 4'd9,
    CMD_BEQ  = 4'd10
  } cmd_t;

  // Operation class decided by the front end
  typedef enum logic [2:0] {
    OP_NONE,
    OP_JUMP,
    OP_ALU,
    OP_DIV,
    OP_LOAD,
    OP_STORE,
    OP_BRANCH,
    OP_FAULT
  } op_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_ADDI,
    ALU_SUBI
  } alu_t;

  // Raw request as it arrives on the input channel
  typedef struct packed {
    logic [3:0]         command;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg;
    logic [4:0]         third_reg;
    logic signed [31:0] immediate;
    logic [11:0]        byte_address;
    logic [9:0]         target_index;
    logic [9:0]         current_index;
  } in_req_t;

  // Classified request held in the queue
  typedef struct packed {
    op_t         op;
    alu_t        alu;
    logic [4:0]  rd;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [31:0] imm;
    logic [MemAw-1:0] word;
    logic [10:0] target;   // already clamped
    logic [10:0] next_seq; // current + 1
    logic [9:0]  cur;
  } dec_req_t;

  typedef struct packed {
    logic [10:0]        next_index;
    logic               executed_flag;
    logic               address_fault;
    logic signed [31:0] written_value;
  } out_res_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_READ,
    EX_MUL,
    EX_DIV,
    EX_DIVFIX,
    EX_LOAD,
    EX_DONE
  } ex_state_t;

endpackage

`default_nettype wire

// File: rtl/mse_if.sv
// ============================================================================
// mse_if: valid/ready channel
// Carries one request type with a source and a sink side.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface mse_in_if;
  logic              valid;
  logic              ready;
  mse_pkg::in_req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mse_out_if;
  logic              valid;
  logic              ready;
  mse_pkg::out_res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/mips_subset_instruction_executor_top.sv
// ============================================================================
// mips_subset_instruction_executor_top: MIPS subset executor
// Front end classifies and queues requests; back end executes them.
// ============================================================================
// Each request passes through the execute unit's EX_READ and EX_DONE states;
// mul adds EX_MUL, lw adds EX_LOAD and div adds EX_DIV and EX_DIVFIX, the
// one-bit-per-cycle divider. A finished result waits in an output register,
// so the next request can start while it is unclaimed; the unit stalls only
// when a second result is ready before the first has been taken. After reset
// a clearing sweep zeroes the data memory; requests queue but are not
// executed until it ends. The front queue holds two requests.
`timescale 1ns / 1ps
`default_nettype none

module mips_subset_instruction_executor_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mse_in_if.sink     in_ch,
  mse_out_if.source  out_ch
);

  mse_pkg::dec_req_t q_data;
  logic              q_valid;
  logic              q_pop;

  mse_front u_front (
    .clk, .rst_n, .in_ch, .q_data, .q_valid, .q_pop
  );

  mse_back u_back (
    .clk, .rst_n, .q_data, .q_valid, .q_pop, .out_ch
  );

endmodule

`default_nettype wire

// File: rtl/mse_front.sv
// ============================================================================
// mse_front: decode stage and request queue
// Classifies each request (alignment, target clamp, memory word) and
// queues it for the execute unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mse_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  mse_in_if.sink                  in_ch,
  output mse_pkg::dec_req_t       q_data,
  output logic                    q_valid,
  input  wire logic               q_pop
);

  localparam int unsigned PtrW = $clog2(mse_pkg::QDepth);

  mse_pkg::dec_req_t mem_r [mse_pkg::QDepth];
  logic [PtrW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PtrW:0]     cnt_r, cnt_nxt;
  mse_pkg::dec_req_t dec;
  logic              push;

  // Classification
  always_comb begin
    dec          = '0;
    dec.rd       = in_ch.data.dest_reg;
    dec.rs       = in_ch.data.src_reg;
    dec.rt       = in_ch.data.third_reg;
    dec.imm      = in_ch.data.immediate;
    dec.word     = in_ch.data.byte_address[mse_pkg::MemAw+1:2];
    dec.cur      = in_ch.data.current_index;
    dec.next_seq = {1'b0, in_ch.data.current_index} + 11'd1;
    dec.target   = ({1'b0, in_ch.data.target_index} >= 11'(mse_pkg::ProgramLines)) ?
                   11'(mse_pkg::ProgramLines) : {1'b0, in_ch.data.target_index};
    dec.op       = mse_pkg::OP_NONE;
    dec.alu      = mse_pkg::ALU_ADD;
    case (in_ch.data.command)
      mse_pkg::CMD_J:    dec.op = mse_pkg::OP_JUMP;
      mse_pkg::CMD_ADD:  begin dec.op = mse_pkg::OP_ALU; dec.alu = mse_pkg::ALU_ADD;  end
      mse_pkg::CMD_SUB:  begin dec.op = mse_pkg::OP_ALU; dec.alu = mse_pkg::ALU_SUB;  end
      mse_pkg::CMD_MUL:  begin dec.op = mse_pkg::OP_ALU; dec.alu = mse_pkg::ALU_MUL;  end
      mse_pkg::CMD_DIV:  dec.op = mse_pkg::OP_DIV;
      mse_pkg::CMD_ADDI: begin dec.op = mse_pkg::OP_ALU; dec.alu = mse_pkg::ALU_ADDI; end
      mse_pkg::CMD_SUBI: begin dec.op = mse_pkg::OP_ALU; dec.alu = mse_pkg::ALU_SUBI; end
      mse_pkg::CMD_LW:
        dec.op = (in_ch.data.byte_address[1:0] != 2'b00) ? mse_pkg::OP_FAULT
                                                           : mse_pkg::OP_LOAD;
      mse_pkg::CMD_SW:
        dec.op = (in_ch.data.byte_address[1:0] != 2'b00) ? mse_pkg::OP_FAULT
                                                           : mse_pkg::OP_STORE;
      mse_pkg::CMD_BEQ:  dec.op = mse_pkg::OP_BRANCH;
      default:           dec.op = mse_pkg::OP_NONE;
    endcase
  end

  assign in_ch.ready = (cnt_r != (PtrW+1)'(mse_pkg::QDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_data      = mem_r[rp_r];

  // Queue pointers
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = q_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= dec;
  end

endmodule

`default_nettype wire

// File: rtl/mse_back.sv
// ============================================================================
// mse_back: execute unit
// Register file, data memory with clearing sweep, multiplier and a
// one-bit-per-cycle restoring divider. Holds the result until taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mse_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  mse_pkg::dec_req_t       q_data,
  input  wire logic               q_valid,
  output logic                    q_pop,
  mse_out_if.source               out_ch
);

  localparam int unsigned Aw = mse_pkg::MemAw;

  logic [31:0] rf_r [32];
  logic [31:0] dmem_r [mse_pkg::MemWords];

  mse_pkg::ex_state_t st_r, st_nxt;
  mse_pkg::dec_req_t  req_r;
  logic [31:0] a_r, b_r, d_r;       // rs, rt, rd operands
  logic [31:0] rd_data_r;           // memory read data
  logic [63:0] prod_r;
  logic [31:0] quo_r, rem_r, den_r;
  logic [5:0]  dcnt_r;
  logic        dneg_r;
  logic        clr_r;
  logic [Aw:0] clr_cnt_r;
  mse_pkg::out_res_t res_r;         // output register
  mse_pkg::out_res_t wres_r, wres_nxt; // result being built
  logic        ov_r;

  logic        rf_we;
  logic [31:0] rf_wd;
  logic        mem_we;
  logic [Aw-1:0] mem_wa;
  logic [31:0] mem_wd;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] alu_val;
  logic        hand_off;

  assign out_ch.valid = ov_r;
  assign out_ch.data  = res_r;
  assign q_pop        = (st_r == mse_pkg::EX_IDLE) && q_valid && !clr_r;
  assign hand_off     = (st_r == mse_pkg::EX_DONE) && (!ov_r || out_ch.ready);

  assign rem_sh = {rem_r[30:0], quo_r[31]};
  assign trial  = {1'b0, rem_sh} - {1'b0, den_r};

  always_comb begin
    case (req_r.alu)
      mse_pkg::ALU_ADD:  alu_val = a_r + b_r;
      mse_pkg::ALU_SUB:  alu_val = a_r - b_r;
      mse_pkg::ALU_ADDI: alu_val = a_r + req_r.imm;
      mse_pkg::ALU_SUBI: alu_val = a_r - req_r.imm;
      default:           alu_val = a_r + b_r;
    endcase
  end

  // Sequencer
  always_comb begin
    st_nxt   = st_r;
    wres_nxt = wres_r;
    rf_we    = 1'b0;
    rf_wd    = '0;
    mem_we   = 1'b0;
    mem_wa   = req_r.word;
    mem_wd   = d_r;
    unique case (st_r)
      mse_pkg::EX_IDLE: if (q_pop) st_nxt = mse_pkg::EX_READ;
      mse_pkg::EX_READ: begin
        wres_nxt.next_index    = req_r.next_seq;
        wres_nxt.executed_flag = 1'b1;
        wres_nxt.address_fault = 1'b0;
        wres_nxt.written_value = '0;
        st_nxt = mse_pkg::EX_DONE;
        case (req_r.op)
          mse_pkg::OP_NONE:  wres_nxt.executed_flag = 1'b0;
          mse_pkg::OP_JUMP:  wres_nxt.next_index = req_r.target;
          mse_pkg::OP_FAULT: begin
            wres_nxt.executed_flag = 1'b0;
            wres_nxt.address_fault = 1'b1;
            wres_nxt.next_index    = {1'b0, req_r.cur};
          end
          mse_pkg::OP_BRANCH: begin
            if (d_r == a_r) wres_nxt.next_index = req_r.target;
            else            wres_nxt.executed_flag = 1'b0;
          end
          mse_pkg::OP_STORE: begin
            mem_we = 1'b1;
            wres_nxt.written_value = d_r;
          end
          mse_pkg::OP_LOAD: st_nxt = mse_pkg::EX_LOAD;
          mse_pkg::OP_DIV:  st_nxt = mse_pkg::EX_DIV;
          mse_pkg::OP_ALU: begin
            if (req_r.alu == mse_pkg::ALU_MUL) st_nxt = mse_pkg::EX_MUL;
            else begin
              rf_we = 1'b1;
              rf_wd = alu_val;
              wres_nxt.written_value = (req_r.rd == 5'd0) ? '0 : alu_val;
            end
          end
          default: ;
        endcase
      end
      mse_pkg::EX_MUL: begin
        rf_we = 1'b1;
        rf_wd = prod_r[31:0];
        wres_nxt.written_value = (req_r.rd == 5'd0) ? '0 : prod_r[31:0];
        st_nxt = mse_pkg::EX_DONE;
      end
      mse_pkg::EX_LOAD: begin
        rf_we = 1'b1;
        rf_wd = rd_data_r;
        wres_nxt.written_value = (req_r.rd == 5'd0) ? '0 : rd_data_r;
        st_nxt = mse_pkg::EX_DONE;
      end
      mse_pkg::EX_DIV: if (dcnt_r == 6'd0) st_nxt = mse_pkg::EX_DIVFIX;
      mse_pkg::EX_DIVFIX: begin
        rf_we = 1'b1;
        rf_wd = (b_r == '0) ? '0 : (dneg_r ? (32'd0 - quo_r) : quo_r);
        wres_nxt.written_value = (req_r.rd == 5'd0) ? '0 : rf_wd;
        st_nxt = mse_pkg::EX_DONE;
      end
      mse_pkg::EX_DONE: if (hand_off) st_nxt = mse_pkg::EX_IDLE;
      default: st_nxt = mse_pkg::EX_IDLE;
    endcase
    if (clr_r) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r[Aw-1:0];
      mem_wd = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= mse_pkg::EX_IDLE;
      ov_r      <= 1'b0;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (Aw+1)'(mse_pkg::MemWords - 1)) clr_r <= 1'b0;
      end
      if (hand_off) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  // Register file, zero on reset; register zero never written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) rf_r[i] <= '0;
    end else if (rf_we && req_r.rd != 5'd0) begin
      rf_r[req_r.rd] <= rf_wd;
    end
  end

  // Data memory
  always_ff @(posedge clk) begin
    if (mem_we) dmem_r[mem_wa] <= mem_wd;
    rd_data_r <= dmem_r[req_r.word];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    wres_r <= wres_nxt;
    // Finished result moves to the output register once it is free
    if (hand_off) res_r <= wres_r;
    if (q_pop) begin
      req_r <= q_data;
      a_r   <= rf_r[q_data.rs];
      b_r   <= rf_r[q_data.rt];
      d_r   <= rf_r[q_data.rd];
    end
    if (st_r == mse_pkg::EX_READ) begin
      prod_r <= a_r * b_r;
      quo_r  <= a_r[31] ? 32'd0 - a_r : a_r;
      den_r  <= b_r[31] ? 32'd0 - b_r : b_r;
      rem_r  <= '0;
      dneg_r <= a_r[31] ^ b_r[31];
      dcnt_r <= 6'd31;
    end else if (st_r == mse_pkg::EX_DIV) begin
      dcnt_r <= dcnt_r - 6'd1;
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire
